FILE: rtl/polar_to_cartesian_macros.svh
// Assertion macros for the checker file of polar_to_cartesian.
// No dependencies; include by bare file name.
`ifndef POLAR_TO_CARTESIAN_MACROS_SVH
`define POLAR_TO_CARTESIAN_MACROS_SVH

// Concurrent assertion, masked while reset is asserted.
`define P2C_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Concurrent assertion that is also checked across reset.
`define P2C_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/p2c_pkg.sv
// Shared types and constants of the polar_to_cartesian CORDIC pipeline.
// Used by every design module of the block (not by p2c_checker); depends on nothing.
package p2c_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int TABLE_LEN       = 24;
    localparam int STAGE_COUNT     = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;
    localparam int SHIFT_W         = $clog2(TABLE_LEN);

    localparam int VEC_W   = 35;
    localparam int ANGLE_W = 32;
    localparam int COORD_W = 17;

    localparam logic signed [16:0] HALF_TURN    = 17'sd23040;
    localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
    localparam logic signed [16:0] QUARTER_TURN = 17'sd11520;
    localparam logic [29:0]        GAIN_Q30     = 30'd652032874;
    localparam logic signed [20:0] OUT_LIMIT    = 21'sd65535;

    // atan(2^-i) in degrees, scaled by 2^23
    localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
        32'sd30000467,  32'sd15014858,  32'sd7509261,   32'sd3754860,
        32'sd1877459,   32'sd938733,    32'sd469367,    32'sd234683,
        32'sd117342,    32'sd58671,     32'sd29335,     32'sd14668,
        32'sd7334,      32'sd3667,      32'sd1833,      32'sd917,
        32'sd458,       32'sd229,       32'sd115,       32'sd57
    };

    typedef struct packed {
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [ANGLE_W-1:0] z;
        logic                      negate;
    } vec_t;

endpackage

FILE: rtl/p2c_prep.sv
// Entry stage: wraps and folds the bearing, scales the range by the CORDIC gain.
// Depends on p2c_pkg.
module p2c_prep (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   bearing,
    input  logic [15:0]          range_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output p2c_pkg::vec_t        out_data
);

    logic               valid_reg;
    p2c_pkg::vec_t      data_reg;
    p2c_pkg::vec_t      data_next;
    logic               advance;
    logic signed [16:0] a_ext;
    logic signed [16:0] a_wrap;
    logic signed [16:0] a_fold;
    logic               fold;
    logic [45:0]        prod;

    always_comb
    begin
        a_ext = {bearing[15], bearing};
        priority if (a_ext > p2c_pkg::HALF_TURN)
        begin
            a_wrap = a_ext - p2c_pkg::FULL_TURN;
        end
        else if (a_ext < -p2c_pkg::HALF_TURN)
        begin
            a_wrap = a_ext + p2c_pkg::FULL_TURN;
        end
        else
        begin
            a_wrap = a_ext;
        end
        fold = 1'b1;
        priority if (a_wrap > p2c_pkg::QUARTER_TURN)
        begin
            a_fold = a_wrap - p2c_pkg::HALF_TURN;
        end
        else if (a_wrap < -p2c_pkg::QUARTER_TURN)
        begin
            a_fold = a_wrap + p2c_pkg::HALF_TURN;
        end
        else
        begin
            a_fold = a_wrap;
            fold   = 1'b0;
        end
        prod             = 46'(range_value) * 46'(p2c_pkg::GAIN_Q30);
        data_next.x      = signed'({3'b000, prod[45:14]});
        data_next.y      = '0;
        data_next.z      = signed'({a_fold[15:0], 16'h0000});
        data_next.negate = fold;
    end

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/p2c_cell.sv
// One CORDIC rotation cell: a micro-rotation by the given shift and arctangent.
// Depends on p2c_pkg.
module p2c_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [p2c_pkg::SHIFT_W-1:0]          shift_amt,
    input  logic signed [p2c_pkg::ANGLE_W-1:0]   atan_val,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  p2c_pkg::vec_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output p2c_pkg::vec_t                        out_data
);

    logic                              valid_reg;
    p2c_pkg::vec_t                     data_reg;
    p2c_pkg::vec_t                     data_next;
    logic signed [p2c_pkg::VEC_W-1:0]  dx;
    logic signed [p2c_pkg::VEC_W-1:0]  dy;
    logic                              advance;

    always_comb
    begin
        dx        = in_data.y >>> shift_amt;
        dy        = in_data.x >>> shift_amt;
        data_next = in_data;
        // rotate toward zero residual angle
        if (!in_data.z[p2c_pkg::ANGLE_W-1])
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - atan_val;
        end
        else
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + atan_val;
        end
    end

    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

FILE: rtl/p2c_finish.sv
// Output stage: rounds the vector, undoes the fold, saturates, holds the result.
// Depends on p2c_pkg.
module p2c_finish (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  p2c_pkg::vec_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [p2c_pkg::COORD_W-1:0]   x_coord,
    output logic signed [p2c_pkg::COORD_W-1:0]   y_coord
);

    logic                                valid_reg;
    logic signed [p2c_pkg::COORD_W-1:0]  x_reg;
    logic signed [p2c_pkg::COORD_W-1:0]  y_reg;
    logic signed [p2c_pkg::COORD_W-1:0]  x_next;
    logic signed [p2c_pkg::COORD_W-1:0]  y_next;
    logic                                advance;

    function automatic logic signed [p2c_pkg::COORD_W-1:0] round_sat(
        input logic signed [p2c_pkg::VEC_W-1:0] v,
        input logic                             negate
    );
        logic signed [p2c_pkg::VEC_W:0] rnd;
        logic signed [20:0]             r;
        logic signed [20:0]             rn;
        logic signed [p2c_pkg::COORD_W-1:0] res;
        // round half up, then drop the 16 fraction bits
        rnd = {v[p2c_pkg::VEC_W-1], v} + 36'sd32768;
        r   = {rnd[p2c_pkg::VEC_W], rnd[p2c_pkg::VEC_W:16]};
        rn  = negate ? -r : r;
        priority if (rn > p2c_pkg::OUT_LIMIT)
        begin
            res = p2c_pkg::OUT_LIMIT[p2c_pkg::COORD_W-1:0];
        end
        else if (rn < -p2c_pkg::OUT_LIMIT)
        begin
            res = -(p2c_pkg::OUT_LIMIT[p2c_pkg::COORD_W-1:0]);
        end
        else
        begin
            res = rn[p2c_pkg::COORD_W-1:0];
        end
        return res;
    endfunction

    assign x_next    = round_sat(in_data.x, in_data.negate);
    assign y_next    = round_sat(in_data.y, in_data.negate);
    assign advance   = !valid_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg;
    assign x_coord   = x_reg;
    assign y_coord   = y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

endmodule

FILE: rtl/polar_to_cartesian.sv
// polar_to_cartesian: bearing and range in, Cartesian point out.
// Input item on s_axis: bearing in 1/128 degree (signed), range in 1/256.
// Result item on m_axis: x = range*cos, y = range*sin, in 1/256, saturated
// to +-65535. Each item runs through a chain of registered cells: an entry
// cell that wraps and folds the bearing into +-90 degrees and scales the
// range by the CORDIC gain (one 16x30 multiply), one rotation cell per
// CORDIC stage (16 by default), and an output cell that rounds, restores
// the fold and saturates.
// Throughput is one item per cycle while m_axis_tready stays high; every
// cell then passes its item to the next one each cycle.
// Each cell is its own skid point: when m_axis_tready is low the result
// holds and empty cells upstream keep filling, so s_axis_tready drops only
// once every cell holds an item. No item is lost or repeated.
// Reset clears all valid flags; the block is stateless otherwise and is
// ready for items in the first cycle after reset.
// Depends on p2c_pkg, p2c_prep, p2c_cell, p2c_finish.
module polar_to_cartesian (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bearing [15:0], range_value [31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // x_coord [16:0], y_coord [33:17], zero [39:34]
);

    localparam int N = p2c_pkg::STAGE_COUNT;

    p2c_pkg::vec_t                       stage_data [N+1];
    logic                                stage_valid [N+1];
    logic                                stage_ready [N+1];
    logic signed [p2c_pkg::COORD_W-1:0]  x_coord;
    logic signed [p2c_pkg::COORD_W-1:0]  y_coord;

    p2c_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .bearing     (signed'(s_axis_tdata[15:0])),
        .range_value (s_axis_tdata[31:16]),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_data    (stage_data[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        p2c_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_amt (p2c_pkg::SHIFT_W'(i)),
            .atan_val  (p2c_pkg::ATAN_TABLE[i]),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    p2c_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stage_valid[N]),
        .in_ready  (stage_ready[N]),
        .in_data   (stage_data[N]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .x_coord   (x_coord),
        .y_coord   (y_coord)
    );

    assign m_axis_tdata = {6'b000000, y_coord, x_coord};

endmodule

FILE: rtl/p2c_checker.sv
// Port-level checks for polar_to_cartesian, bound to the top level.
// Depends on polar_to_cartesian_macros.svh.
`include "polar_to_cartesian_macros.svh"

module p2c_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a stalled result stays offered
    `P2C_ASSERT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    // saturation never lets a coordinate reach -65536
    `P2C_ASSERT(a_x_sat, clk, rst_n, m_axis_tvalid |-> m_axis_tdata[16:0] != 17'h10000)
    `P2C_ASSERT(a_y_sat, clk, rst_n, m_axis_tvalid |-> m_axis_tdata[33:17] != 17'h10000)
    // nothing is offered right out of reset
    `P2C_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> !m_axis_tvalid)

endmodule

bind polar_to_cartesian p2c_checker u_p2c_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
